// ===== rtl/core/life_generation_step_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the life generation step block
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STEP_ASSERT_SVH
`define LIFE_GENERATION_STEP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define LGS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in every cycle
`define LGS_ASSERT_ALW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and the B3/S23 rule for the life generation step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    // Default number of cells in the chain
    localparam int LGS_MAX_WIDTH = 32;

    // Fixed field widths
    localparam int LGS_ROW_W     = 8;
    localparam int LGS_OUT_COL_W = 5;
    localparam int LGS_GW_W      = 6;
    localparam int LGS_GH_W      = 8;
    localparam int LGS_CFG_W     = 8;
    localparam int LGS_CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [LGS_CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    // Next-generation cell codes
    typedef enum logic [1:0] {
        ST_DEAD     = 2'd0,
        ST_SURVIVED = 2'd1,
        ST_NEWBORN  = 2'd2
    } t_cell_state;

    // What one cell shows its neighbors
    typedef struct packed {
        logic        a;
        logic        m;
        logic        tok;
        t_cell_state drain;
    } t_link;

    // Controls broadcast to every cell
    typedef struct packed {
        logic wr;
        logic row_end;
        logic alive;
        logic load;
        logic shift;
    } t_cell_ctl;

    // Results owed for one accepted item
    typedef struct packed {
        logic                 held;
        logic                 norm;
        logic                 tail;
        logic                 drain;
        t_cell_state          norm_state;
        t_cell_state          tail_state;
        logic [LGS_ROW_W-1:0] row;
    } t_job;

    // Status of the result sequencer
    typedef struct packed {
        logic job_busy;
        logic job_done;
        logic drain_busy;
        logic held_valid;
        logic load;
        logic shift;
    } t_seq_stat;

    // Judge a 3x3 window: bit 3*row+col, row 0 on top, centre at bit 4
    function automatic t_cell_state lgs_judge(input logic [8:0] win);
        logic [3:0]  count;
        t_cell_state st;
        count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                count = count + 4'(win[i]);
            end
        end
        if (!win[4] && count == 4'd3) begin
            st = ST_NEWBORN;
        end else if (win[4] && (count == 4'd2 || count == 4'd3)) begin
            st = ST_SURVIVED;
        end else begin
            st = ST_DEAD;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lgs_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_cell
// One column of the line stores: holds the two rows above the input, passes
// the column token along, judges its column of the last row and shifts the
// judged states toward the head of the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_cell
    import lgs_pkg::*;
#(
    parameter bit HEAD = 1'b0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_link     i_left,
    input  wire t_link     i_right,
    input  wire logic      i_right_use,
    output t_link          o_link,
    output logic [1:0]     o_hit
);

    logic        r_tok;
    logic        r_above;
    logic        r_middle;
    t_cell_state r_drain;
    logic [8:0]  win;

    // Advance the column token, reload at row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= HEAD;
        end else if (i_ctl.wr) begin
            r_tok <= i_ctl.row_end ? HEAD : i_left.tok;
        end
    end

    // Shift this column's rows down by one when the token is here
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && r_tok) begin
            r_above  <= r_middle;
            r_middle <= i_ctl.alive;
        end
    end

    // Build the last-row window, clip at the right grid edge
    assign win = {3'b000,
                  i_right.m & i_right_use, r_middle, i_left.m,
                  i_right.a & i_right_use, r_above,  i_left.a};

    // Load judged states, then hand them toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_drain <= lgs_judge(win);
        end else if (i_ctl.shift) begin
            r_drain <= i_right.drain;
        end
    end

    assign o_link.a     = r_above;
    assign o_link.m     = r_middle;
    assign o_link.tok   = r_tok;
    assign o_link.drain = r_drain;
    assign o_hit        = {r_tok & r_above, r_tok & r_middle};

endmodule

`default_nettype wire

// ===== rtl/core/lgs_seq.sv =====
// ----------------------------------------------------------------------------
// lgs_seq
// Result sequencer: holds the results owed for one item, sends them one per
// cycle unless stalled, through the output register, including the last-row drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_seq
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH = LGS_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_new,
    input  wire t_job                     i_job,
    input  wire logic [CW-1:0]            i_job_col,
    input  wire logic [WW-1:0]            i_w_use,
    input  wire t_cell_state              i_drain_state,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic [1:0]                    o_cell_state,
    output logic [LGS_ROW_W-1:0]          o_out_row,
    output logic [LGS_OUT_COL_W-1:0]      o_out_column,
    output logic                          o_run_last,
    output logic                          o_generation_end,
    output t_seq_stat                     o_stat
);

    `include "life_generation_step_assert.svh"

    logic                     r_job_valid;
    t_job                     r_job;
    logic [CW-1:0]            r_col;
    logic [CW-1:0]            r_dcol;
    logic                     r_held_valid;
    t_cell_state              r_held_state;
    logic [LGS_ROW_W-1:0]     r_held_row;
    logic [CW-1:0]            r_held_col;
    logic                     r_out_valid;
    t_cell_state              r_out_state;
    logic [LGS_ROW_W-1:0]     r_out_row;
    logic [LGS_OUT_COL_W-1:0] r_out_col;
    logic                     r_out_last;
    logic                     r_out_gend;

    logic                     can_emit;
    logic                     drain_phase;
    logic                     held_case;
    logic [CW-1:0]            w_m1;
    logic [CW-1:0]            w_m2;
    logic                     capture;
    logic                     emit;
    logic                     job_done;
    logic                     load;
    logic                     shift;
    t_cell_state              cur_state;
    logic [LGS_ROW_W-1:0]     cur_row;
    logic [CW-1:0]            cur_col;
    logic                     cur_last;
    logic                     cur_gend;

    // Decode the current phase of the job
    assign can_emit    = !r_out_valid || !i_out_stall;
    assign drain_phase = r_job.drain && !r_job.held && !r_job.norm && !r_job.tail;
    assign held_case   = (i_w_use == WW'(MAX_WIDTH));
    assign w_m1        = CW'(i_w_use - WW'(1));
    assign w_m2        = CW'(i_w_use - WW'(2));
    assign capture     = r_job_valid && drain_phase && held_case && (r_dcol == w_m1);
    assign emit        = r_job_valid && can_emit && !capture;
    assign load        = r_job_valid && r_job.drain && !drain_phase;
    assign shift       = emit && drain_phase;

    // Pick the result to send this cycle
    always_comb begin
        if (r_job.held) begin
            cur_state = r_held_state;
            cur_row   = r_held_row;
            cur_col   = r_held_col;
            cur_gend  = 1'b1;
            cur_last  = !(r_job.norm || r_job.tail || r_job.drain);
        end else if (r_job.norm) begin
            cur_state = r_job.norm_state;
            cur_row   = r_job.row - LGS_ROW_W'(1);
            cur_col   = r_col - CW'(1);
            cur_gend  = 1'b0;
            cur_last  = !(r_job.tail || r_job.drain);
        end else if (r_job.tail) begin
            cur_state = r_job.tail_state;
            cur_row   = r_job.row - LGS_ROW_W'(1);
            cur_col   = r_col;
            cur_gend  = 1'b0;
            cur_last  = !r_job.drain;
        end else begin
            cur_state = i_drain_state;
            cur_row   = r_job.row;
            cur_col   = r_dcol;
            cur_gend  = (r_dcol == w_m1);
            cur_last  = held_case ? (r_dcol == w_m2) : (r_dcol == w_m1);
        end
    end

    // In the widest grid the job ends only once the final cell is kept
    assign job_done = r_job_valid
                    && ((emit && cur_last && !(drain_phase && held_case)) || capture);

    // Advance the job, the drain column and the held cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid  <= 1'b0;
            r_job        <= '0;
            r_col        <= '0;
            r_dcol       <= '0;
            r_held_valid <= 1'b0;
        end else begin
            if (i_new) begin
                r_job_valid <= 1'b1;
                r_job       <= i_job;
                r_col       <= i_job_col;
            end else begin
                if (job_done) begin
                    r_job_valid <= 1'b0;
                end
                if (emit) begin
                    if (r_job.held) begin
                        r_job.held <= 1'b0;
                    end else if (r_job.norm) begin
                        r_job.norm <= 1'b0;
                    end else if (r_job.tail) begin
                        r_job.tail <= 1'b0;
                    end else if (r_dcol == w_m1) begin
                        r_job.drain <= 1'b0;
                    end
                end else if (capture) begin
                    r_job.drain <= 1'b0;
                end
            end
            if (load) begin
                r_dcol <= '0;
            end else if (shift) begin
                r_dcol <= r_dcol + CW'(1);
            end
            if (i_new && i_job.held) begin
                r_held_valid <= 1'b0;
            end else if (capture) begin
                r_held_valid <= 1'b1;
            end
        end
    end

    // Keep the generation's final cell when it does not fit
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_held_state <= i_drain_state;
            r_held_row   <= r_job.row;
            r_held_col   <= r_dcol;
        end
    end

    // Hold the output item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_state <= cur_state;
            r_out_row   <= cur_row;
            r_out_col   <= LGS_OUT_COL_W'(cur_col);
            r_out_last  <= cur_last;
            r_out_gend  <= cur_gend;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_state     = r_out_state;
    assign o_out_row        = r_out_row;
    assign o_out_column     = r_out_col;
    assign o_run_last       = r_out_last;
    assign o_generation_end = r_out_gend;

    assign o_stat.job_busy   = r_job_valid;
    assign o_stat.job_done   = job_done;
    assign o_stat.drain_busy = r_job_valid && r_job.drain;
    assign o_stat.held_valid = r_held_valid;
    assign o_stat.load       = load;
    assign o_stat.shift      = shift;

    // A live job always owes at least one result
    `LGS_ASSERT_IMP(a_job_owes, r_job_valid,
        (r_job.held || r_job.norm || r_job.tail || r_job.drain), "empty job")
    // A new job arrives only when the slot frees up
    `LGS_ASSERT_IMP(a_new_free, i_new, (!r_job_valid || job_done), "job overrun")
    // The drain column stays inside the grid
    `LGS_ASSERT_IMP(a_dcol_range, (r_job_valid && drain_phase), (r_dcol <= w_m1),
        "drain column past grid")

endmodule

`default_nettype wire

// ===== rtl/core/life_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_generation_step: one B3/S23 Game of Life generation over a raster cell stream
// Results: an item's results wait as a job, then leave through the output register.
// Rate: one item per cycle while the job slot frees up; after a generation's last item
//   the input stalls while the last row drains from the chain.
// Reset (sync, low): clears counters, window, token and pending results; registers
//   return to 10 x 10, stores keep data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH = LGS_MAX_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr,
    input  wire logic [LGS_CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LGS_CFG_W-1:0]     i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_cell_alive,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_cell_state,
    output logic [LGS_ROW_W-1:0]          o_out_row,
    output logic [LGS_OUT_COL_W-1:0]      o_out_column,
    output logic                          o_run_last,
    output logic                          o_generation_end
);

    `include "life_generation_step_assert.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [8:0] KEEP_OLD_COLS = 9'h0DB;

    logic [LGS_GW_W-1:0]  r_grid_width;
    logic [LGS_GH_W-1:0]  r_grid_height;
    logic [LGS_ROW_W-1:0] r_row;
    logic [CW-1:0]        r_col;
    logic [8:0]           r_win;

    logic [WW-1:0]        w_use;
    logic [LGS_GH_W-1:0]  h_use;
    logic [WW-1:0]        col_inc;
    logic [LGS_ROW_W:0]   row_inc;
    logic                 row_end;
    logic                 last;
    logic                 accept;
    logic                 above_bit;
    logic                 middle_bit;
    logic [8:0]           win_base;
    logic [8:0]           win_new;
    logic                 has_norm;
    logic                 has_tail;
    logic                 needs_job;
    t_job                 job;
    t_seq_stat            stat;
    t_cell_ctl            ctl;

    t_link                links    [MAX_WIDTH];
    t_link                left_in  [MAX_WIDTH];
    t_link                right_in [MAX_WIDTH];
    logic [1:0]           hits     [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] right_use;
    logic [MAX_WIDTH-1:0] tok_vec;
    logic [MAX_WIDTH-1:0] hit_a;
    logic [MAX_WIDTH-1:0] hit_m;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= LGS_GW_W'(10);
            r_grid_height <= LGS_GH_W'(10);
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[LGS_GW_W-1:0];
                end
                CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[LGS_GH_W-1:0];
                end
            endcase
        end
    end

    // Clamp the grid size to the range in use
    always_comb begin
        if (r_grid_width < LGS_GW_W'(3)) begin
            w_use = WW'(3);
        end else if ({1'b0, r_grid_width} > (LGS_GW_W + 1)'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(r_grid_width);
        end
    end

    assign h_use = (r_grid_height < LGS_GH_W'(3)) ? LGS_GH_W'(3) : r_grid_height;

    // Find row and generation ends
    assign col_inc = WW'(r_col) + WW'(1);
    assign row_inc = {1'b0, r_row} + (LGS_ROW_W + 1)'(1);
    assign row_end = (col_inc >= w_use);
    assign last    = row_end && (row_inc >= {1'b0, h_use});

    // Read this column from the chain, rows above the grid are dead
    assign above_bit  = (|hit_a) && (r_row >= LGS_ROW_W'(2));
    assign middle_bit = (|hit_m) && (r_row != '0);

    // Slide the 3x3 window by one column
    assign win_base = (r_col == '0) ? '0 : r_win;
    assign win_new  = ((win_base >> 1) & KEEP_OLD_COLS)
                    | (9'(above_bit) << 2)
                    | (9'(middle_bit) << 5)
                    | (9'(i_cell_alive) << 8);

    // Work out which results this item owes
    assign has_norm  = (r_row != '0) && (r_col != '0);
    assign has_tail  = (r_row != '0) && row_end;
    assign needs_job = stat.held_valid || has_norm || has_tail || last;

    // Stall while the last row drains or the job slot stays full
    assign o_in_stall = stat.drain_busy || (needs_job && stat.job_busy && !stat.job_done);
    assign accept     = i_in_valid && !o_in_stall;

    assign job.held       = stat.held_valid;
    assign job.norm       = has_norm;
    assign job.tail       = has_tail;
    assign job.drain      = last;
    assign job.norm_state = lgs_judge(win_new);
    assign job.tail_state = lgs_judge((win_new >> 1) & KEEP_OLD_COLS);
    assign job.row        = r_row;

    // Advance the raster counters and the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_win <= '0;
        end else if (accept) begin
            r_win <= win_new;
            if (row_end) begin
                r_col <= '0;
                r_row <= last ? '0 : row_inc[LGS_ROW_W-1:0];
            end else begin
                r_col <= CW'(col_inc);
            end
        end
    end

    assign ctl.wr      = accept;
    assign ctl.row_end = row_end;
    assign ctl.alive   = i_cell_alive;
    assign ctl.load    = stat.load;
    assign ctl.shift   = stat.shift;

    // Chain of column cells
    for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
        if (g == 0) begin : g_left_edge
            assign left_in[g] = '0;
        end else begin : g_left_nbr
            assign left_in[g] = links[g-1];
        end
        if (g == MAX_WIDTH - 1) begin : g_right_edge
            assign right_in[g] = '0;
        end else begin : g_right_nbr
            assign right_in[g] = links[g+1];
        end
        assign right_use[g] = (WW'(g + 1) < w_use);

        lgs_cell #(
            .HEAD (1'(g == 0))
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_left      (left_in[g]),
            .i_right     (right_in[g]),
            .i_right_use (right_use[g]),
            .o_link      (links[g]),
            .o_hit       (hits[g])
        );

        assign tok_vec[g] = links[g].tok;
        assign hit_a[g]   = hits[g][1];
        assign hit_m[g]   = hits[g][0];
    end

    lgs_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_new            (accept && needs_job),
        .i_job            (job),
        .i_job_col        (r_col),
        .i_w_use          (w_use),
        .i_drain_state    (links[0].drain),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_cell_state     (o_cell_state),
        .o_out_row        (o_out_row),
        .o_out_column     (o_out_column),
        .o_run_last       (o_run_last),
        .o_generation_end (o_generation_end),
        .o_stat           (stat)
    );

    // Exactly one cell holds the column token
    `LGS_ASSERT_ALW(a_tok_onehot, $onehot(tok_vec), "column token not one-hot")
    // The token sits at the column counter
    `LGS_ASSERT_ALW(a_tok_at_col, tok_vec[r_col], "column token off the counter")

endmodule

`default_nettype wire

// ===== tb/life_generation_step_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_generation_step_tb
// Streams Game of Life grids cell by cell through the generation step block
// and checks every next-generation cell, its position and its end flags
// against a behavioral prediction of the B3/S23 rule, the line buffers and
// the last-row drain. Runs under random valid gaps and output stalls.
// ---------------------------------------------------------------------------

module life_generation_step_tb;
    import lgs_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int COLS_MAX        = LGS_MAX_WIDTH;
    localparam int RESULTS_MAX     = COLS_MAX + 1;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 300;
    localparam int LIMIT_CYCLES    = 300_000;
    localparam logic [8:0] KEEP_SIDE_COLS = 9'h0DB;
    localparam logic [8:0] BLINKER        = 9'b010_010_010;

    // One next-generation cell as the block should emit it
    typedef struct packed {
        t_cell_state              state;
        logic [LGS_ROW_W-1:0]     row;
        logic [LGS_OUT_COL_W-1:0] column;
        logic                     run_last;
        logic                     gen_end;
    } t_next_cell;

    // Predict next-generation cells and hold them until the block emits them
    class generation_scoreboard;
        bit                  above_row [COLS_MAX];
        bit                  middle_row [COLS_MAX];
        logic [8:0]          window;
        int                  row_cnt;
        int                  col_cnt;
        logic [LGS_GW_W-1:0] width_reg;
        logic [LGS_GH_W-1:0] height_reg;
        bit                  held_valid;
        t_next_cell          held_cell;
        t_next_cell          owed_cells [$];
        int                  fail_count;

        function new();
            foreach (above_row[i]) begin
                above_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            window     = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            width_reg  = 6'd10;
            height_reg = 8'd10;
            held_valid = 1'b0;
            held_cell  = '0;
            fail_count = 0;
        endfunction

        // Clamp the width to 3..MAX and the height to at least 3
        function int cols_in_use();
            int w;
            w = int'(width_reg);
            if (w < 3) w = 3;
            if (w > COLS_MAX) w = COLS_MAX;
            return w;
        endfunction

        function int rows_in_use();
            return (int'(height_reg) < 3) ? 3 : int'(height_reg);
        endfunction

        function int owed_count();
            return owed_cells.size();
        endfunction

        function void write_register(t_cfg_idx idx, logic [LGS_CFG_W-1:0] data);
            if (idx == CFG_GRID_WIDTH) width_reg = data[LGS_GW_W-1:0];
            else height_reg = data[LGS_GH_W-1:0];
        endfunction

        // Birth on exactly three neighbors, survival on two or three
        function t_cell_state next_state(logic [8:0] win);
            int count;
            count = 0;
            for (int i = 0; i < 9; i++) begin
                if (i != 4) count += int'(win[i]);
            end
            if (!win[4] && count == 3) return ST_NEWBORN;
            if (win[4] && (count == 2 || count == 3)) return ST_SURVIVED;
            return ST_DEAD;
        endfunction

        function t_next_cell make_cell(t_cell_state st, int row, int col, bit gen_end);
            t_next_cell nc;
            nc.state    = st;
            nc.row      = LGS_ROW_W'(row);
            nc.column   = LGS_OUT_COL_W'(col);
            nc.run_last = 1'b0;
            nc.gen_end  = gen_end;
            return nc;
        endfunction

        // Read a buffered cell; columns off the grid are dead
        function bit stored(bit from_above, int col, int w);
            if (col < 0 || col >= w) return 1'b0;
            return from_above ? above_row[col] : middle_row[col];
        endfunction

        // Advance the window by one accepted cell and queue what it completes
        function void note_cell(bit alive);
            t_next_cell batch [$];
            int         w, h, r, c;
            bit         above, middle, row_end, last_cell;
            logic [8:0] drain_win;
            w = cols_in_use();
            h = rows_in_use();
            r = row_cnt;
            c = col_cnt;
            above  = 1'b0;
            middle = 1'b0;
            if (held_valid) begin
                batch.push_back(held_cell);
                held_valid = 1'b0;
            end
            // rows above the top of the grid are dead
            if (r >= 2) above = above_row[c];
            if (r >= 1) middle = middle_row[c];
            above_row[c]  = middle;
            middle_row[c] = alive;
            if (c == 0) window = '0;
            window = ((window >> 1) & KEEP_SIDE_COLS) | (9'(above) << 2)
                   | (9'(middle) << 5) | (9'(alive) << 8);
            row_end   = (c + 1 >= w);
            last_cell = row_end && (r + 1 >= h);
            if (r >= 1) begin
                if (c >= 1) batch.push_back(make_cell(next_state(window), r - 1, c - 1, 1'b0));
                if (row_end) begin
                    batch.push_back(make_cell(next_state((window >> 1) & KEEP_SIDE_COLS),
                                              r - 1, c, 1'b0));
                end
            end
            // drain the last row; past the result limit the final cell waits
            if (last_cell) begin
                for (int k = 0; k < w; k++) begin
                    drain_win = '0;
                    for (int j = 0; j < 3; j++) begin
                        drain_win[j]     = stored(1'b1, k - 1 + j, w);
                        drain_win[3 + j] = stored(1'b0, k - 1 + j, w);
                    end
                    if (batch.size() < RESULTS_MAX) begin
                        batch.push_back(make_cell(next_state(drain_win), r, k, k + 1 == w));
                    end else begin
                        held_valid = 1'b1;
                        held_cell  = make_cell(next_state(drain_win), r, k, 1'b1);
                    end
                end
            end
            if (row_end) begin
                col_cnt = 0;
                row_cnt = last_cell ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
            if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
            foreach (batch[i]) owed_cells.push_back(batch[i]);
        endfunction

        // Compare one emitted cell with the oldest owed cell
        function void check_cell(logic [1:0] state, logic [LGS_ROW_W-1:0] row,
                                 logic [LGS_OUT_COL_W-1:0] column, logic run_last,
                                 logic gen_end);
            t_next_cell exp_cell;
            if (owed_cells.size() == 0) begin
                $error("unexpected result at row %0d column %0d", row, column);
                fail_count++;
                return;
            end
            exp_cell = owed_cells.pop_front();
            if (state !== exp_cell.state) begin
                $error("cell_state mismatch: expected %0d, actual %0d", exp_cell.state, state);
                fail_count++;
            end
            if (row !== exp_cell.row) begin
                $error("out_row mismatch: expected %0d, actual %0d", exp_cell.row, row);
                fail_count++;
            end
            if (column !== exp_cell.column) begin
                $error("out_column mismatch: expected %0d, actual %0d", exp_cell.column, column);
                fail_count++;
            end
            if (run_last !== exp_cell.run_last) begin
                $error("run_last mismatch: expected %0d, actual %0d", exp_cell.run_last, run_last);
                fail_count++;
            end
            if (gen_end !== exp_cell.gen_end) begin
                $error("generation_end mismatch: expected %0d, actual %0d",
                       exp_cell.gen_end, gen_end);
                fail_count++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr;
    logic [LGS_CFG_IDX_W-1:0] i_cfg_idx;
    logic [LGS_CFG_W-1:0]     i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_cell_alive;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_cell_state;
    logic [LGS_ROW_W-1:0]     o_out_row;
    logic [LGS_OUT_COL_W-1:0] o_out_column;
    logic                     o_run_last;
    logic                     o_generation_end;

    generation_scoreboard book;
    int send_idle_pct;
    int recv_idle_pct;
    int burst_ask;
    int burst_seen;

    life_generation_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr         (i_cfg_wr),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cell_alive     (i_cell_alive),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cell_state     (o_cell_state),
        .o_out_row        (o_out_row),
        .o_out_column     (o_out_column),
        .o_run_last       (o_run_last),
        .o_generation_end (o_generation_end)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Stall the output at random, or for a long stretch when asked
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        burst_seen  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst_ask != burst_seen) begin
                burst_seen = burst_ask;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            book.check_cell(o_cell_state, o_out_row, o_out_column, o_run_last,
                            o_generation_end);
        end
    end

    // Write one register while the block is idle
    task automatic write_register(input t_cfg_idx idx, input logic [LGS_CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_wr <= 1'b0;
        book.write_register(idx, data);
    endtask

    task automatic configure(input logic [LGS_CFG_W-1:0] width_data,
                             input logic [LGS_CFG_W-1:0] height_data);
        write_register(CFG_GRID_WIDTH, width_data);
        write_register(CFG_GRID_HEIGHT, height_data);
    endtask

    // Offer one cell, with random gaps ahead of it, and hold it until taken
    task automatic send_cell(input bit alive);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cell_alive <= alive;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        book.note_cell(alive);
    endtask

    task automatic send_random(input int count, input int density);
        repeat (count) send_cell($urandom_range(99) < density);
    endtask

    // Drop valid, wait for every owed cell, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (book.owed_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : watchdog
        #(CLK_HALF * 2 * LIMIT_CYCLES);
        $display("life_generation_step regression: fail");
        $finish;
    end

    initial begin : stimulus
        int          density;
        int          pick;
        int          cells;
        int          random_items;
        bit          burst_done;
        logic [7:0]  w_data;
        logic [7:0]  h_data;
        i_rst_n       = 1'b0;
        i_cfg_wr      = 1'b0;
        i_cfg_idx     = CFG_GRID_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_cell_alive  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        burst_ask     = 0;
        book          = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out-of-range registers fold to 3 x 3; a vertical blinker turns flat
        configure(8'd0, 8'd1);
        for (int i = 0; i < 9; i++) send_cell(BLINKER[i]);
        // full grid: corners survive, the rest is crowded out
        repeat (9) send_cell(1'b1);
        settle();

        // widest grid: the final drained cell waits for the next first item
        configure(8'd63, 8'd2);
        send_random(book.cols_in_use() * book.rows_in_use(), 50);
        settle();

        // shrink width and height partway through a generation
        configure(8'd8, 8'd5);
        send_random(2 * 8 + 6, 50);
        settle();
        configure(8'd5, 8'd3);
        send_cell(1'b1);
        settle();

        random_items = 0;
        burst_done   = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            // pick the idle mix for this stretch
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 54;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!burst_done && random_items >= 2 * RANDOM_ITEMS / 3) begin
                w_data = 8'd32;
                h_data = 8'd4;
            end else begin
                pick = $urandom_range(99);
                if (pick < 10) w_data = 8'($urandom_range(32, 63));
                else if (pick < 16) w_data = 8'($urandom_range(0, 2));
                else if (pick < 22) begin
                    w_data = 8'($urandom_range(3, 12)) | 8'($urandom_range(1, 3) << 6);
                end
                else w_data = 8'($urandom_range(3, 12));
                pick = $urandom_range(99);
                if (pick < 12) h_data = 8'($urandom_range(0, 2));
                else h_data = 8'($urandom_range(3, 8));
            end
            configure(w_data, h_data);
            pick = $urandom_range(99);
            if (pick < 5) density = 0;
            else if (pick < 10) density = 100;
            else density = $urandom_range(15, 85);
            cells = book.cols_in_use() * book.rows_in_use();
            // hold the output off long enough for the block to back up
            if (!burst_done && w_data == 8'd32 && h_data == 8'd4) begin
                burst_done = 1'b1;
                burst_ask++;
            end
            send_random(cells, density);
            settle();
            random_items += cells;
        end

        if (book.fail_count == 0) begin
            $display("life_generation_step regression: pass");
        end else begin
            $display("life_generation_step regression: fail");
        end
        $finish;
    end

endmodule
